@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/mcfs_pkg.sv @@
// Shared types, codes and sizes of the multi-channel FIFO select block.
package mcfs_pkg;

    localparam int ACTION_W = 2;
    localparam int CHAN_W   = 3;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 4;
    localparam int GROUP_W  = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int NUM_CHANNELS_DEF  = 8;
    localparam int CHANNEL_DEPTH_DEF = 8;

    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);
    localparam int OUTQ_DEPTH  = 4;
    localparam int OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);

    localparam logic [ACTION_W-1:0] ACT_SEND   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RECV   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SELECT = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CLOSE  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BLOCK  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CLOSED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP    = 2'd1;

    localparam logic [CAP_W-1:0]   CAP_RESET   = 4'd8;
    localparam logic [GROUP_W-1:0] GROUP_RESET = 8'd0;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CHAN_W-1:0]   src;
        logic                mem_rd;
        logic                mem_wr;
    } cmd_ctl_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [CHAN_W-1:0]         src;
        logic signed [VALUE_W-1:0] value;
    } result_t;

endpackage

@@ rtl/multi_channel_fifo_select_core.sv @@
// Top level of the multi-channel FIFO block with priority select.
//
// Input channel: present action, channel and send_value with push; a word is
// taken at a clock edge where push is high and full is low.
// Result channel: while empty is low the oldest result sits on status,
// source_channel and recv_value; pop at an edge where empty is low takes it.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 capacity, 1 group
// mask) and cfg_data; cfg_ready is always high, other indexes are ignored.
// Every word produces exactly one result, in order.
// A taken word passes the command queue, the read stage register and the result
// queue before its result shows. Throughput: one word per cycle while full is low;
// the front end updates the channel bookkeeping in the cycle a word is taken, and
// the back end does one entry memory access per cycle while the result queue has room.
// When the receiver stalls, the four-entry result queue fills, the back end
// stops draining the two-entry command queue, and full rises.
// Reset empties every channel, reopens all channels, sets capacity to eight
// and the group mask to zero; it takes effect at once with no clearing pass.
module multi_channel_fifo_select_core #(
    parameter int NUM_CHANNELS  = mcfs_pkg::NUM_CHANNELS_DEF,
    parameter int CHANNEL_DEPTH = mcfs_pkg::CHANNEL_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [mcfs_pkg::ACTION_W-1:0]        action,
    input  logic [mcfs_pkg::CHAN_W-1:0]          channel,
    input  logic signed [mcfs_pkg::VALUE_W-1:0]  send_value,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [mcfs_pkg::STATUS_W-1:0]        status,
    output logic [mcfs_pkg::CHAN_W-1:0]          source_channel,
    output logic signed [mcfs_pkg::VALUE_W-1:0]  recv_value,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mcfs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mcfs_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import mcfs_pkg::*;

    localparam int CHAN_SPAN = 1 << CHAN_W;
    localparam int USED_CH   = (NUM_CHANNELS < CHAN_SPAN) ? NUM_CHANNELS : CHAN_SPAN;
    localparam int MEM_DEPTH = USED_CH * CHANNEL_DEPTH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CTL_W     = $bits(cmd_ctl_t);
    localparam int CMD_W     = CTL_W + ADDR_W + VALUE_W;
    localparam int RES_W     = $bits(result_t);

    logic                  accept;
    cmd_ctl_t              f_ctl;
    logic [ADDR_W-1:0]     f_addr;
    logic [CMD_W-1:0]      cq_wdata;
    logic [CMD_W-1:0]      cq_rdata;
    logic [CMDQ_CNT_W-1:0] cq_count;
    cmd_ctl_t              b_ctl;
    logic [ADDR_W-1:0]     b_addr;
    logic [VALUE_W-1:0]    b_wdata;
    logic                  cq_pop;
    logic                  res_push;
    result_t               res_in;
    result_t               res_out;
    logic [RES_W-1:0]      oq_rdata;
    logic [OUTQ_CNT_W-1:0] oq_count;

    assign full      = (cq_count == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign accept    = push && !full;
    assign cfg_ready = 1'b1;

    mcfs_front #(
        .NUM_CHANNELS  (NUM_CHANNELS),
        .CHANNEL_DEPTH (CHANNEL_DEPTH),
        .ADDR_W        (ADDR_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .action    (action),
        .channel   (channel),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_ctl   (f_ctl),
        .cmd_addr  (f_addr)
    );

    assign cq_wdata = {f_ctl, f_addr, send_value};

    mcfs_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .wdata (cq_wdata),
        .pop   (cq_pop),
        .rdata (cq_rdata),
        .count (cq_count)
    );

    assign b_ctl   = cmd_ctl_t'(cq_rdata[CMD_W-1 -: CTL_W]);
    assign b_addr  = cq_rdata[VALUE_W +: ADDR_W];
    assign b_wdata = cq_rdata[VALUE_W-1:0];

    mcfs_back #(
        .NUM_CHANNELS  (NUM_CHANNELS),
        .CHANNEL_DEPTH (CHANNEL_DEPTH),
        .ADDR_W        (ADDR_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cq_count != '0),
        .cmd_ctl   (b_ctl),
        .cmd_addr  (b_addr),
        .cmd_wdata (b_wdata),
        .out_count (oq_count),
        .cmd_pop   (cq_pop),
        .res_push  (res_push),
        .res_data  (res_in)
    );

    mcfs_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUTQ_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .pop   (pop && !empty),
        .rdata (oq_rdata),
        .count (oq_count)
    );

    assign res_out        = result_t'(oq_rdata);
    assign empty          = (oq_count == '0);
    assign status         = res_out.status;
    assign source_channel = res_out.src;
    assign recv_value     = res_out.value;

endmodule

@@ rtl/mcfs_fifo.sv @@
// Small register-based FIFO used for the command queue and the result queue.
module mcfs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [WIDTH-1:0]             wdata,
    input  logic                         pop,
    output logic [WIDTH-1:0]             rdata,
    output logic [$clog2(DEPTH+1)-1:0]   count
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wdata;
    end

    assign rdata = slot_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

@@ rtl/mcfs_front.sv @@
// Front end: holds channel bookkeeping and configuration, classifies each word.
module mcfs_front #(
    parameter int NUM_CHANNELS  = mcfs_pkg::NUM_CHANNELS_DEF,
    parameter int CHANNEL_DEPTH = mcfs_pkg::CHANNEL_DEPTH_DEF,
    parameter int ADDR_W        = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [mcfs_pkg::ACTION_W-1:0]     action,
    input  logic [mcfs_pkg::CHAN_W-1:0]       channel,
    input  logic                              cfg_write,
    input  logic [mcfs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mcfs_pkg::CFG_DATA_W-1:0]   cfg_data,
    output mcfs_pkg::cmd_ctl_t                cmd_ctl,
    output logic [ADDR_W-1:0]                 cmd_addr
);
    import mcfs_pkg::*;

    localparam int CHAN_SPAN = 1 << CHAN_W;
    localparam int USED_CH   = (NUM_CHANNELS < CHAN_SPAN) ? NUM_CHANNELS : CHAN_SPAN;
    localparam int CI_W      = (USED_CH > 1) ? $clog2(USED_CH) : 1;
    localparam int PTR_W     = (CHANNEL_DEPTH > 1) ? $clog2(CHANNEL_DEPTH) : 1;
    localparam int CNT_W     = $clog2(CHANNEL_DEPTH + 1);

    logic [PTR_W-1:0]   rd_ptr_reg [USED_CH];
    logic [PTR_W-1:0]   wr_ptr_reg [USED_CH];
    logic [CNT_W-1:0]   fill_reg   [USED_CH];
    logic [USED_CH-1:0] closed_reg;
    logic [CAP_W-1:0]   cap_reg;
    logic [GROUP_W-1:0] group_reg;

    logic               ch_ok;
    logic [CI_W-1:0]    ch_idx;
    logic [USED_CH-1:0] hit;
    logic               any_member;
    logic               open_member;
    logic [CI_W-1:0]    pick;
    logic [CI_W-1:0]    tgt;
    logic [31:0]        cap_eff;
    logic               do_push;
    logic               do_pop;
    logic               do_close;
    logic [STATUS_W-1:0] status;
    logic [CHAN_W-1:0]  src;
    logic [PTR_W-1:0]   ptr_sel;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(CHANNEL_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    // Scan of the group: members holding data, and whether any member is still open.
    always_comb
    begin
        any_member  = 1'b0;
        open_member = 1'b0;
        pick        = '0;
        for (int i = 0; i < USED_CH; i++)
        begin
            hit[i]      = group_reg[i] && (fill_reg[i] != '0);
            any_member  = any_member | group_reg[i];
            open_member = open_member | (group_reg[i] && !closed_reg[i]);
        end
        for (int i = USED_CH - 1; i >= 0; i--)
        begin
            if (hit[i])
                pick = CI_W'(i);
        end
    end

    always_comb
    begin
        ch_ok  = (32'(channel) < 32'(NUM_CHANNELS));
        ch_idx = CI_W'(channel);
        tgt    = (action == ACT_SELECT) ? pick : ch_idx;

        cap_eff = 32'(cap_reg);
        if (cap_eff == 32'd0)
            cap_eff = 32'd1;
        if (cap_eff > 32'(CHANNEL_DEPTH))
            cap_eff = 32'(CHANNEL_DEPTH);

        do_push  = 1'b0;
        do_pop   = 1'b0;
        do_close = 1'b0;
        status   = ST_DONE;
        src      = channel;

        if (action == ACT_SELECT)
        begin
            if (hit != '0)
            begin
                do_pop = 1'b1;
                src    = CHAN_W'(pick);
            end
            else
            begin
                src    = '0;
                status = (any_member && !open_member) ? ST_CLOSED : ST_BLOCK;
            end
        end
        else if (!ch_ok)
        begin
            status = ST_CLOSED;
        end
        else
        begin
            case (action)
                ACT_SEND:
                begin
                    if (closed_reg[tgt])
                        status = ST_CLOSED;
                    else if (32'(fill_reg[tgt]) >= cap_eff)
                        status = ST_BLOCK;
                    else
                        do_push = 1'b1;
                end
                ACT_RECV:
                begin
                    if (fill_reg[tgt] != '0)
                        do_pop = 1'b1;
                    else
                        status = closed_reg[tgt] ? ST_CLOSED : ST_BLOCK;
                end
                ACT_CLOSE:
                    do_close = 1'b1;
                default:
                    status = ST_DONE;
            endcase
        end

        ptr_sel = do_push ? wr_ptr_reg[tgt] : rd_ptr_reg[tgt];
    end

    assign cmd_ctl.status = status;
    assign cmd_ctl.src    = src;
    assign cmd_ctl.mem_rd = do_pop;
    assign cmd_ctl.mem_wr = do_push;
    assign cmd_addr = ADDR_W'(tgt) * ADDR_W'(CHANNEL_DEPTH) + ADDR_W'(ptr_sel);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < USED_CH; i++)
            begin
                rd_ptr_reg[i] <= '0;
                wr_ptr_reg[i] <= '0;
                fill_reg[i]   <= '0;
            end
            closed_reg <= '0;
            cap_reg    <= CAP_RESET;
            group_reg  <= GROUP_RESET;
        end
        else
        begin
            if (accept)
            begin
                if (do_push)
                begin
                    wr_ptr_reg[tgt] <= ptr_inc(wr_ptr_reg[tgt]);
                    fill_reg[tgt]   <= fill_reg[tgt] + 1'b1;
                end
                if (do_pop)
                begin
                    rd_ptr_reg[tgt] <= ptr_inc(rd_ptr_reg[tgt]);
                    fill_reg[tgt]   <= fill_reg[tgt] - 1'b1;
                end
                if (do_close)
                    closed_reg[tgt] <= 1'b1;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_CAPACITY: cap_reg   <= cfg_data[CAP_W-1:0];
                    CFG_GROUP:    group_reg <= cfg_data[GROUP_W-1:0];
                    default:      cap_reg   <= cap_reg;
                endcase
            end
        end
    end

endmodule

@@ rtl/mcfs_back.sv @@
// Back end: entry memory access for queued commands and result formation.
module mcfs_back #(
    parameter int NUM_CHANNELS  = mcfs_pkg::NUM_CHANNELS_DEF,
    parameter int CHANNEL_DEPTH = mcfs_pkg::CHANNEL_DEPTH_DEF,
    parameter int ADDR_W        = 6
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_valid,
    input  mcfs_pkg::cmd_ctl_t                   cmd_ctl,
    input  logic [ADDR_W-1:0]                    cmd_addr,
    input  logic signed [mcfs_pkg::VALUE_W-1:0]  cmd_wdata,
    input  logic [mcfs_pkg::OUTQ_CNT_W-1:0]      out_count,
    output logic                                 cmd_pop,
    output logic                                 res_push,
    output mcfs_pkg::result_t                    res_data
);
    import mcfs_pkg::*;

    localparam int CHAN_SPAN = 1 << CHAN_W;
    localparam int USED_CH   = (NUM_CHANNELS < CHAN_SPAN) ? NUM_CHANNELS : CHAN_SPAN;
    localparam int MEM_DEPTH = USED_CH * CHANNEL_DEPTH;

    logic [VALUE_W-1:0] mem [MEM_DEPTH];
    logic [VALUE_W-1:0] rdata_reg;
    logic               s2_valid_reg;
    cmd_ctl_t           s2_ctl_reg;

    // A result still in the read stage already holds a slot in the result queue.
    assign cmd_pop = cmd_valid &&
                     ((32'(out_count) + 32'(s2_valid_reg)) < 32'(OUTQ_DEPTH));

    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd_ctl.mem_wr)
            mem[cmd_addr] <= cmd_wdata;
        if (cmd_pop && cmd_ctl.mem_rd)
            rdata_reg <= mem[cmd_addr];
        if (cmd_pop)
            s2_ctl_reg <= cmd_ctl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= cmd_pop;
    end

    assign res_push        = s2_valid_reg;
    assign res_data.status = s2_ctl_reg.status;
    assign res_data.src    = s2_ctl_reg.src;
    assign res_data.value  = s2_ctl_reg.mem_rd ? rdata_reg : '0;

endmodule

@@ rtl/mcfs_checker.sv @@
// Port-level checker for the multi-channel FIFO block and its bind statement.
`include "assert_macros.svh"

module mcfs_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 push,
    input logic                                 full,
    input logic                                 empty,
    input logic                                 pop,
    input logic [mcfs_pkg::STATUS_W-1:0]        status,
    input logic [mcfs_pkg::CHAN_W-1:0]          source_channel,
    input logic signed [mcfs_pkg::VALUE_W-1:0]  recv_value
);
    import mcfs_pkg::*;

    // Only the three defined status codes ever reach the result ports.
    `CHK_IMPLY(a_status_known, clk, rst_n, !empty, (status == ST_DONE || status == ST_BLOCK || status == ST_CLOSED))

    // A result whose status is not done carries a zero value.
    `CHK_IMPLY(a_value_zero, clk, rst_n, !empty && status != ST_DONE, recv_value == '0)

    // A waiting result stays put until it is taken.
    `CHK_NEXT(a_hold_stalled, clk, rst_n, !empty && !pop, !empty && $stable(status) && $stable(source_channel) && $stable(recv_value))

    // The input side can only fill up right after it took a word.
    `CHK_IMPLY(a_full_after_push, clk, rst_n, $rose(full), $past(push))

endmodule

bind multi_channel_fifo_select_core mcfs_checker u_mcfs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .status         (status),
    .source_channel (source_channel),
    .recv_value     (recv_value)
);
